[rtl/core/rtms_pkg.sv]
// Package for the raster-to-Morton tile swizzle.
// Field widths, register indexes, reset values and the in-tile Morton function.
// No dependencies.
package rtms_pkg;

    localparam int MAX_TEX_DIM = 512;
    localparam int MIN_TEX_DIM = 64;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 32;
    localparam int IDX_W     = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 10'd512;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 10'd480;

    // bit order: x0 y0 x1 y1 x2 y2 from LSB up
    function automatic logic [5:0] morton8(input logic [2:0] x, input logic [2:0] y);
        morton8 = {y[2], x[2], y[1], x[1], y[0], x[0]};
    endfunction

endpackage

[rtl/core/raster_to_morton_tile_swizzle_top.sv]
// The result of an item is registered and shows on the output in the cycle after it is accepted.
// Throughput: one item per cycle while no output item is stalled; a single result
// register with its stall fed back to the input sets that rate.
// Reset (i_rst_n low, synchronous): counters cleared, output empty,
// image width 512 and image height 480.
// Depends on rtms_pkg.
module raster_to_morton_tile_swizzle_top #(
    parameter int MAX_TEX_DIM = rtms_pkg::MAX_TEX_DIM,
    parameter int MIN_TEX_DIM = rtms_pkg::MIN_TEX_DIM
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rtms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtms_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rtms_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rtms_pkg::IDX_W-1:0]   o_tile_index,
    output logic [rtms_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                         o_frame_end
);

    localparam int CNT_W   = $clog2(MAX_TEX_DIM);
    localparam int DIM_W   = CNT_W + 1;
    localparam int CMP_W   = (DIM_W > rtms_pkg::CFG_W) ? DIM_W : rtms_pkg::CFG_W;
    localparam int LOG_MAX = $clog2(MAX_TEX_DIM);
    localparam int LOG_MIN = $clog2(MIN_TEX_DIM);
    localparam int LG_W    = $clog2(LOG_MAX + 1);
    localparam int SUM_W   = CNT_W + LOG_MAX;
    localparam int TN_W    = rtms_pkg::IDX_W - 6;

    logic [rtms_pkg::CFG_W-1:0] r_image_width;
    logic [rtms_pkg::CFG_W-1:0] r_image_height;
    logic [CNT_W-1:0]           r_col, n_col;
    logic [CNT_W-1:0]           r_row, n_row;
    logic                       r_out_valid;
    logic [rtms_pkg::IDX_W-1:0] r_tile_index, n_tile_index;
    logic [rtms_pkg::PIX_W-1:0] r_pixel_out;
    logic                       r_frame_end, n_frame_end;

    logic             w_accept;
    logic [DIM_W-1:0] w_width;
    logic [DIM_W-1:0] w_height;
    logic [LG_W-1:0]  w_lg;
    logic [LG_W-1:0]  w_tile_shift;
    logic [SUM_W-1:0] w_tile_no;
    logic             w_row_last;

    function automatic logic [DIM_W-1:0] bound_dim(input logic [rtms_pkg::CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (v == '0) begin
            bound_dim = DIM_W'(1);
        end else if (ve > CMP_W'(MAX_TEX_DIM)) begin
            bound_dim = DIM_W'(MAX_TEX_DIM);
        end else begin
            bound_dim = DIM_W'(ve);
        end
    endfunction

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_width  = bound_dim(r_image_width);
    assign w_height = bound_dim(r_image_height);

    // texture width exponent: ceil(log2(width)), clamped to the texture limits
    always_comb begin
        w_lg = '0;
        for (int k = 0; k < LOG_MAX; k++) begin
            if ((DIM_W'(1) << k) < w_width) begin
                w_lg = LG_W'(k + 1);
            end
        end
        if (w_lg < LG_W'(LOG_MIN)) begin
            w_lg = LG_W'(LOG_MIN);
        end
    end

    assign w_tile_shift = w_lg - LG_W'(3);
    assign w_tile_no    = (SUM_W'(r_row >> 3) << w_tile_shift) + SUM_W'(r_col >> 3);
    assign w_row_last   = (DIM_W'(r_col) + DIM_W'(1)) >= w_width;

    always_comb begin
        n_tile_index = {w_tile_no[TN_W-1:0],
                        rtms_pkg::morton8(r_col[2:0], r_row[2:0])};
        n_frame_end  = w_row_last && ((DIM_W'(r_row) + DIM_W'(1)) >= w_height);
        n_col        = r_col + CNT_W'(1);
        n_row        = r_row;
        if (w_row_last) begin
            n_col = '0;
            n_row = n_frame_end ? '0 : r_row + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rtms_pkg::RST_IMAGE_WIDTH;
            r_image_height <= rtms_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtms_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                rtms_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (!o_in_stall) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tile_index <= n_tile_index;
            r_pixel_out  <= i_pixel_in;
            r_frame_end  <= n_frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tile_index = r_tile_index;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_end  = r_frame_end;

endmodule

[rtl/core/rtms_checker.sv]
// Port-level checker for the raster-to-Morton tile swizzle, with its bind.
// Depends on rtms_pkg and raster_to_morton_tile_swizzle_top.
module rtms_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [rtms_pkg::IDX_W-1:0]   o_tile_index,
    input logic [rtms_pkg::PIX_W-1:0]   o_pixel_out,
    input logic                         o_frame_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tile_index)
            && $stable(o_pixel_out) && $stable(o_frame_end))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item did not reach the output");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output item");

endmodule

bind raster_to_morton_tile_swizzle_top rtms_checker u_rtms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_tile_index (o_tile_index),
    .o_pixel_out  (o_pixel_out),
    .o_frame_end  (o_frame_end)
);
